### design/chkm_pkg.sv
package chkm_pkg;

    localparam int BUCKETS_DEF    = 1024;
    localparam int ENTRIES_DEF    = 2048;
    localparam int VALUE_BITS_DEF = 32;

    localparam int KEY_W = 64;
    localparam int RES_W = 32;

    localparam logic [63:0] MIX_C1 = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] MIX_C2 = 64'h94d049bb133111eb;
    localparam int MIX_S1 = 30;
    localparam int MIX_S2 = 27;
    localparam int MIX_S3 = 31;

    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_PRESENT  = 2'd1,
        ST_ABSENT   = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    localparam logic FUNC_FIND = 1'b0;
    localparam logic FUNC_ADD  = 1'b1;

    // handshake between sequencer and the hash unit
    typedef struct packed {
        logic start;
    } hash_req_t;

    typedef struct packed {
        logic done;
    } hash_rsp_t;

endpackage

### design/chkm_hash.sv
// splitmix64 finalizer; each 64-bit multiply made of 32x32 partial products,
// one partial product per cycle through a single shared multiplier.
module chkm_hash (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  chkm_pkg::hash_req_t   req,
    input  logic [63:0]           key,
    output chkm_pkg::hash_rsp_t   rsp,
    output logic [63:0]           hash
);

    typedef enum logic [2:0] {
        H_IDLE, H_PRE, H_MUL, H_POST, H_DONE
    } hstate_t;

    hstate_t     state_reg;
    logic        round_reg;      // 0: first mix, 1: second mix
    logic [1:0]  pp_reg;         // partial product step
    logic [63:0] x_reg;          // operand
    logic [63:0] acc_reg;        // product accumulator
    logic [63:0] c_sel;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] mul_p;

    assign c_sel = round_reg ? chkm_pkg::MIX_C2 : chkm_pkg::MIX_C1;

    // the single multiplier: lo*lo, lo*hi, hi*lo (hi*hi falls out of 64 bits)
    always_comb begin
        case (pp_reg)
            2'd0:    begin mul_a = x_reg[31:0];  mul_b = c_sel[31:0];  end
            2'd1:    begin mul_a = x_reg[31:0];  mul_b = c_sel[63:32]; end
            default: begin mul_a = x_reg[63:32]; mul_b = c_sel[31:0];  end
        endcase
    end
    assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= H_IDLE;
            round_reg <= 1'b0;
            pp_reg    <= 2'd0;
        end else begin
            case (state_reg)
                H_IDLE: begin
                    if (req.start) begin
                        x_reg     <= key;
                        round_reg <= 1'b0;
                        state_reg <= H_PRE;
                    end
                end
                H_PRE: begin
                    x_reg     <= round_reg ? (x_reg ^ (x_reg >> chkm_pkg::MIX_S2))
                                           : (x_reg ^ (x_reg >> chkm_pkg::MIX_S1));
                    acc_reg   <= 64'd0;
                    pp_reg    <= 2'd0;
                    state_reg <= H_MUL;
                end
                H_MUL: begin
                    if (pp_reg == 2'd0)
                        acc_reg <= acc_reg + mul_p;
                    else
                        acc_reg <= acc_reg + {mul_p[31:0], 32'd0};
                    if (pp_reg == 2'd2) begin
                        state_reg <= H_POST;
                    end
                    pp_reg <= pp_reg + 2'd1;
                end
                H_POST: begin
                    x_reg <= acc_reg;
                    if (round_reg) begin
                        state_reg <= H_DONE;
                    end else begin
                        round_reg <= 1'b1;
                        state_reg <= H_PRE;
                    end
                end
                H_DONE: begin
                    state_reg <= H_IDLE;
                end
                default: state_reg <= H_IDLE;
            endcase
        end
    end

    assign rsp.done = (state_reg == H_DONE);
    assign hash     = x_reg ^ (x_reg >> chkm_pkg::MIX_S3);

endmodule

### design/chkm_store.sv
// Bucket head table and entry store memories. After reset a clearing pass
// writes every head entry empty, one bucket per cycle.
module chkm_store #(
    parameter int BUCKETS    = chkm_pkg::BUCKETS_DEF,
    parameter int ENTRIES    = chkm_pkg::ENTRIES_DEF,
    parameter int VALUE_BITS = chkm_pkg::VALUE_BITS_DEF,
    localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1,
    localparam int EW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    output logic                  clr_busy,
    // head table
    input  logic                  head_rd,
    input  logic [BW-1:0]         head_rd_addr,
    output logic                  head_rd_valid,
    output logic [EW-1:0]         head_rd_data,
    input  logic                  head_wr,
    input  logic [BW-1:0]         head_wr_addr,
    input  logic [EW-1:0]         head_wr_data,
    // entries
    input  logic                  ent_rd,
    input  logic [EW-1:0]         ent_rd_addr,
    output logic [63:0]           ent_rd_key,
    output logic [VALUE_BITS-1:0] ent_rd_value,
    output logic                  ent_rd_link_valid,
    output logic [EW-1:0]         ent_rd_link,
    input  logic                  ent_wr,
    input  logic [EW-1:0]         ent_wr_addr,
    input  logic [63:0]           ent_wr_key,
    input  logic [VALUE_BITS-1:0] ent_wr_value,
    input  logic                  ent_wr_link_valid,
    input  logic [EW-1:0]         ent_wr_link
);

    logic [EW:0]           head_mem [BUCKETS];
    logic [EW:0]           head_q;
    logic                  clr_busy_reg;
    logic [BW-1:0]         clr_addr_reg;
    logic [63:0]           key_mem  [ENTRIES];
    logic [VALUE_BITS-1:0] val_mem  [ENTRIES];
    logic [EW:0]           link_mem [ENTRIES];
    logic [EW:0]           link_q;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else if (clr_busy_reg) begin
            clr_addr_reg <= clr_addr_reg + BW'(1);
            if (clr_addr_reg == BW'(BUCKETS - 1))
                clr_busy_reg <= 1'b0;
        end
    end

    assign clr_busy = clr_busy_reg;

    // head word: {valid, entry index}
    always_ff @(posedge aclk) begin
        if (clr_busy_reg)
            head_mem[clr_addr_reg] <= '0;
        else if (head_wr)
            head_mem[head_wr_addr] <= {1'b1, head_wr_data};
        if (head_rd)
            head_q <= head_mem[head_rd_addr];
    end

    assign head_rd_valid = head_q[EW];
    assign head_rd_data  = head_q[EW-1:0];

    always_ff @(posedge aclk) begin
        if (ent_wr) begin
            key_mem[ent_wr_addr]  <= ent_wr_key;
            val_mem[ent_wr_addr]  <= ent_wr_value;
            link_mem[ent_wr_addr] <= {ent_wr_link_valid, ent_wr_link};
        end
        if (ent_rd) begin
            ent_rd_key   <= key_mem[ent_rd_addr];
            ent_rd_value <= val_mem[ent_rd_addr];
            link_q       <= link_mem[ent_rd_addr];
        end
    end

    assign ent_rd_link_valid = link_q[EW];
    assign ent_rd_link       = link_q[EW-1:0];

endmodule

### design/chained_hash_key_map_core.sv
// Channel   Dir  tdata (low bit up)                          tuser / tlast
// s_axis    in   key[63:0], value[95:64], zero pad to 96     tuser = func
// m_axis    out  status[1:0], value_valid[2], result_value   none
//                [34:3], zero pad to 40
//
// One item at a time: the hash (two mixes, three partial products each
// through one 32x32 multiplier), the head read, then a read per chain link
// visited, the update, loading the result register and an idle state to take
// the next transfer.
// The result register frees the input side; only a result still waiting in
// it when the next one is ready stalls the sequencer until m_axis_tready.
// Reset (aresetn low, synchronous) zeroes the entry count and starts a
// clearing pass over the bucket heads (s_axis_tready low).
// BUCKETS must be a power of two: the bucket is the low bits of the hash.
module chained_hash_key_map_core #(
    parameter int BUCKETS    = chkm_pkg::BUCKETS_DEF,
    parameter int ENTRIES    = chkm_pkg::ENTRIES_DEF,
    parameter int VALUE_BITS = chkm_pkg::VALUE_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [95:0] s_axis_tdata,   // key[63:0], value[95:64]
    input  logic        s_axis_tuser,   // func
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata    // status[1:0], value_valid[2], result_value[34:3]
);

    localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int EW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int RW = chkm_pkg::RES_W;

    typedef enum logic [2:0] {
        S_IDLE, S_HASH, S_HEAD, S_HEADW, S_ENT, S_ENTW, S_UPD, S_OUT
    } state_t;

    state_t                 state_reg;
    logic                   func_reg;
    logic [63:0]            key_reg;
    logic [VALUE_BITS-1:0]  val_reg;
    logic [BW-1:0]          bucket_reg;
    logic                   hd_vld_reg;
    logic [EW-1:0]          hd_reg;
    logic [EW-1:0]          idx_reg;
    logic [CW-1:0]          steps_reg;
    logic [CW-1:0]          count_reg;
    logic                   found_reg;
    logic [VALUE_BITS-1:0]  found_val_reg;
    logic [1:0]             st_reg;
    logic                   vv_reg;
    logic [RW-1:0]          rv_reg;
    logic                   out_vld_reg;
    logic [RW+2:0]          out_data_reg;

    chkm_pkg::hash_req_t    hreq;
    chkm_pkg::hash_rsp_t    hrsp;
    logic [63:0]            hash;
    logic [BW-1:0]          hash_bucket;

    logic                   clr_busy;
    logic                   head_rd_valid;
    logic [EW-1:0]          head_rd_data;
    logic [63:0]            ent_rd_key;
    logic [VALUE_BITS-1:0]  ent_rd_value;
    logic                   ent_rd_link_valid;
    logic [EW-1:0]          ent_rd_link;
    logic                   ins;
    logic [VALUE_BITS-1:0]  in_val;

    assign hreq.start = (state_reg == S_IDLE) && s_axis_tvalid && s_axis_tready;

    assign hash_bucket = hash[BW-1:0];

    generate
        if (VALUE_BITS >= 32) begin : g_vwide
            assign in_val = VALUE_BITS'(s_axis_tdata[95:64]);
        end else begin : g_vnarrow
            assign in_val = s_axis_tdata[64 +: VALUE_BITS];
        end
    endgenerate

    chkm_hash u_hash (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (hreq),
        .key     (s_axis_tdata[63:0]),
        .rsp     (hrsp),
        .hash    (hash)
    );

    assign ins = (state_reg == S_UPD) && !found_reg && (func_reg == chkm_pkg::FUNC_ADD)
                 && (count_reg < CW'(ENTRIES));

    chkm_store #(
        .BUCKETS    (BUCKETS),
        .ENTRIES    (ENTRIES),
        .VALUE_BITS (VALUE_BITS)
    ) u_store (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .clr_busy          (clr_busy),
        .head_rd           (state_reg == S_HEAD),
        .head_rd_addr      (bucket_reg),
        .head_rd_valid     (head_rd_valid),
        .head_rd_data      (head_rd_data),
        .head_wr           (ins),
        .head_wr_addr      (bucket_reg),
        .head_wr_data      (count_reg[EW-1:0]),
        .ent_rd            (state_reg == S_ENT),
        .ent_rd_addr       (idx_reg),
        .ent_rd_key        (ent_rd_key),
        .ent_rd_value      (ent_rd_value),
        .ent_rd_link_valid (ent_rd_link_valid),
        .ent_rd_link       (ent_rd_link),
        .ent_wr            (ins),
        .ent_wr_addr       (count_reg[EW-1:0]),
        .ent_wr_key        (key_reg),
        .ent_wr_value      (val_reg),
        .ent_wr_link_valid (hd_vld_reg),
        .ent_wr_link       (hd_reg)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            out_vld_reg <= 1'b0;
        end else begin
            // S_OUT handles the output register itself
            if (out_vld_reg && m_axis_tready && (state_reg != S_OUT))
                out_vld_reg <= 1'b0;
            case (state_reg)
                S_IDLE: begin
                    if (s_axis_tvalid && s_axis_tready) begin
                        func_reg  <= s_axis_tuser;
                        key_reg   <= s_axis_tdata[63:0];
                        val_reg   <= in_val;
                        found_reg <= 1'b0;
                        state_reg <= S_HASH;
                    end
                end
                S_HASH: begin
                    if (hrsp.done) begin
                        bucket_reg <= hash_bucket;
                        state_reg  <= S_HEAD;
                    end
                end
                S_HEAD: state_reg <= S_HEADW;
                S_HEADW: begin
                    hd_vld_reg <= head_rd_valid;
                    hd_reg     <= head_rd_data;
                    idx_reg    <= head_rd_data;
                    steps_reg  <= '0;
                    state_reg  <= head_rd_valid ? S_ENT : S_UPD;
                end
                S_ENT: state_reg <= S_ENTW;
                S_ENTW: begin
                    if (ent_rd_key == key_reg) begin
                        found_reg     <= 1'b1;
                        found_val_reg <= ent_rd_value;
                        state_reg     <= S_UPD;
                    end else if (ent_rd_link_valid && (steps_reg < CW'(ENTRIES - 1))) begin
                        idx_reg   <= ent_rd_link;
                        steps_reg <= steps_reg + CW'(1);
                        state_reg <= S_ENT;
                    end else begin
                        state_reg <= S_UPD;
                    end
                end
                S_UPD: begin
                    if (found_reg) begin
                        st_reg <= chkm_pkg::ST_PRESENT;
                        vv_reg <= 1'b1;
                        rv_reg <= RW'(found_val_reg);
                    end else if (func_reg == chkm_pkg::FUNC_FIND) begin
                        st_reg <= chkm_pkg::ST_ABSENT;
                        vv_reg <= 1'b0;
                        rv_reg <= '0;
                    end else if (!ins) begin
                        st_reg <= chkm_pkg::ST_FULL;
                        vv_reg <= 1'b0;
                        rv_reg <= '0;
                    end else begin
                        st_reg    <= chkm_pkg::ST_INSERTED;
                        vv_reg    <= 1'b1;
                        rv_reg    <= RW'(val_reg);
                        count_reg <= count_reg + CW'(1);
                    end
                    state_reg <= S_OUT;
                end
                S_OUT: begin
                    if (!out_vld_reg || m_axis_tready) begin
                        out_vld_reg  <= 1'b1;
                        out_data_reg <= {rv_reg, vv_reg, st_reg};
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (state_reg == S_IDLE) && !clr_busy;
    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {5'd0, out_data_reg};

    assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg <= CW'(ENTRIES)))
        else $error("entry count beyond store size");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_UPD) && ins |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("insert did not advance entry count");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && (m_axis_tdata[1:0] == chkm_pkg::ST_ABSENT
                          || m_axis_tdata[1:0] == chkm_pkg::ST_FULL)
        |-> !m_axis_tdata[2])
        else $error("miss or full reported with a value");

endmodule
